// File: rtl/core/ssw_pkg.sv
// ----------------------------------------------------------------------------
// ssw_pkg
// Shared types, constants and the arctangent table of the swirl warp.
// ----------------------------------------------------------------------------
`default_nettype none

package ssw_pkg;

	localparam int CoordWidth = 16;
	localparam int GuardBits  = 8;
	localparam int Stages     = 16;
	localparam int RadWidth   = 15;
	localparam int VecWidth   = 28;
	localparam int AngWidth   = 36;
	localparam int QuoWidth   = 30;
	localparam int DivWidth   = RadWidth + GuardBits;

	typedef logic signed [VecWidth-1:0]   vec_t;
	typedef logic signed [AngWidth-1:0]   ang_t;
	typedef logic signed [CoordWidth-1:0] coord_t;
	typedef logic [RadWidth-1:0]          rad_t;
	typedef logic [QuoWidth-1:0]          quo_t;
	typedef logic [DivWidth-1:0]          div_t;

	typedef struct packed {
		logic   valid;
		logic   bypass;
		coord_t xi;
		coord_t yi;
	} side_t;

	localparam ang_t AngPi     = 36'sd3373259426;
	localparam ang_t AngHalfPi = 36'sd1686629713;
	localparam ang_t AngTwoPi  = 36'sd6746518852;
	localparam logic [29:0] GainK  = 30'd652032874;
	localparam logic [29:0] GainK2 = 30'd395948876;
	localparam rad_t RadReset = 15'd4096;

	function automatic ang_t atan_q30(input logic [4:0] i);
		ang_t r;
		unique case (i)
			5'd0:  r = 36'sd843314857;
			5'd1:  r = 36'sd497837829;
			5'd2:  r = 36'sd263043837;
			5'd3:  r = 36'sd133525159;
			5'd4:  r = 36'sd67021687;
			5'd5:  r = 36'sd33543516;
			5'd6:  r = 36'sd16775851;
			5'd7:  r = 36'sd8388437;
			5'd8:  r = 36'sd4194283;
			5'd9:  r = 36'sd2097149;
			5'd10: r = 36'sd1048576;
			5'd11: r = 36'sd524288;
			5'd12: r = 36'sd262144;
			5'd13: r = 36'sd131072;
			5'd14: r = 36'sd65536;
			5'd15: r = 36'sd32768;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/ssw_vector.sv
// ----------------------------------------------------------------------------
// ssw_vector
// Vectoring CORDIC pipeline: magnitude and angle of the input point.
// ----------------------------------------------------------------------------
`default_nettype none

module ssw_vector (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire ssw_pkg::side_t side_in,
	output ssw_pkg::side_t      side_out,
	output ssw_pkg::vec_t       mag,
	output ssw_pkg::ang_t       ang
);

	ssw_pkg::vec_t  x_s  [ssw_pkg::Stages+1];
	ssw_pkg::vec_t  y_s  [ssw_pkg::Stages+1];
	ssw_pkg::ang_t  z_s  [ssw_pkg::Stages+1];
	ssw_pkg::side_t sd_s [ssw_pkg::Stages+1];
	ssw_pkg::vec_t  xe, ye;

	// left half plane: negate and start at pi
	always_comb begin
		xe = ssw_pkg::vec_t'(side_in.xi) <<< ssw_pkg::GuardBits;
		ye = ssw_pkg::vec_t'(side_in.yi) <<< ssw_pkg::GuardBits;
		sd_s[0] = side_in;
		if (xe < 0) begin
			x_s[0] = -xe;
			y_s[0] = -ye;
			z_s[0] = ssw_pkg::AngPi;
		end else begin
			x_s[0] = xe;
			y_s[0] = ye;
			z_s[0] = '0;
		end
	end

	for (genvar i = 0; i < ssw_pkg::Stages; i++) begin : g_stage
		ssw_pkg::vec_t xs, ys;
		ssw_pkg::ang_t at;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		assign at = ssw_pkg::atan_q30(5'(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sd_s[i+1] <= '0;
			end else if (en) begin
				sd_s[i+1] <= sd_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + at;
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - at;
				end
			end
		end
	end

	assign side_out = sd_s[ssw_pkg::Stages];
	assign mag      = x_s[ssw_pkg::Stages];
	assign ang      = z_s[ssw_pkg::Stages];

endmodule

`default_nettype wire

// File: rtl/core/ssw_falloff.sv
// ----------------------------------------------------------------------------
// ssw_falloff
// Gain correction, radius test, restoring divider, cubic fall-off and
// angle reduction ahead of the rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module ssw_falloff (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire ssw_pkg::rad_t  radius,
	input  wire ssw_pkg::side_t side_in,
	input  wire ssw_pkg::vec_t  mag,
	input  wire ssw_pkg::ang_t  ang,
	output ssw_pkg::side_t      side_out,
	output ssw_pkg::vec_t       rx,
	output ssw_pkg::ang_t       rz
);

	localparam int DivSteps = ssw_pkg::QuoWidth;

	ssw_pkg::div_t rad;
	assign rad = {radius, ssw_pkg::GuardBits'(0)};

	// gain products
	logic [40:0] ph_s1, ph2_s1;
	logic [45:0] pl_s1, pl2_s1;
	ssw_pkg::ang_t  z_s1;
	ssw_pkg::side_t sd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_s1 <= '0;
		end else if (en) begin
			sd_s1 <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1  <= 41'(mag[26:16]) * 41'(ssw_pkg::GainK);
			pl_s1  <= 46'(mag[15:0]) * 46'(ssw_pkg::GainK);
			ph2_s1 <= 41'(mag[26:16]) * 41'(ssw_pkg::GainK2);
			pl2_s1 <= 46'(mag[15:0]) * 46'(ssw_pkg::GainK2);
			z_s1   <= ang;
		end
	end

	// magnitude, radius test
	logic [27:0] d_c, rm_c;
	logic        out_c;
	assign d_c   = 28'(ph_s1 >> 14) + 28'(pl_s1 >> 30);
	assign rm_c  = 28'(ph2_s1 >> 14) + 28'(pl2_s1 >> 30);
	assign out_c = d_c >= 28'(rad);

	ssw_pkg::div_t  rem_s [DivSteps+1];
	ssw_pkg::quo_t  q_s   [DivSteps+1];
	ssw_pkg::vec_t  rm_s  [DivSteps+1];
	ssw_pkg::ang_t  z_s   [DivSteps+1];
	ssw_pkg::side_t sd_s  [DivSteps+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_s[0] <= '0;
		end else if (en) begin
			sd_s[0] <= '{valid: sd_s1.valid, bypass: out_c, xi: sd_s1.xi, yi: sd_s1.yi};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= rad - d_c[ssw_pkg::DivWidth-1:0];
			q_s[0]   <= '0;
			rm_s[0]  <= ssw_pkg::vec_t'(rm_c);
			z_s[0]   <= z_s1;
		end
	end

	// one quotient bit per stage
	for (genvar i = 0; i < DivSteps; i++) begin : g_div
		logic [ssw_pkg::DivWidth:0] t;
		logic                       ge;
		assign t  = {rem_s[i], 1'b0};
		assign ge = t >= {1'b0, rad};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sd_s[i+1] <= '0;
			end else if (en) begin
				sd_s[i+1] <= sd_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? ssw_pkg::DivWidth'(t - {1'b0, rad})
				                 : t[ssw_pkg::DivWidth-1:0];
				q_s[i+1]   <= {q_s[i][ssw_pkg::QuoWidth-2:0], ge};
				rm_s[i+1]  <= rm_s[i];
				z_s[i+1]   <= z_s[i];
			end
		end
	end

	// cube and angle update
	ssw_pkg::quo_t  sq_c1, q_c1, s3_c2;
	ssw_pkg::vec_t  rm_c1, rm_c2, rm_a1, rm_a2, rm_a3;
	ssw_pkg::ang_t  z_c1, z_c2, z_a1, z_a2, z_a3;
	ssw_pkg::side_t sd_c1, sd_c2, sd_a1, sd_a2, sd_a3;
	logic [59:0]    p1, p2;
	ssw_pkg::ang_t  z1_n, z2_n, z3_n;

	assign p1 = 60'(q_s[DivSteps]) * 60'(q_s[DivSteps]);
	assign p2 = 60'(sq_c1) * 60'(q_c1);

	always_comb begin
		z1_n = z_c2 + ssw_pkg::ang_t'({s3_c2, 2'b00}) + ssw_pkg::ang_t'(s3_c2);
		if (z_a1 > ssw_pkg::AngPi) begin
			z2_n = z_a1 - ssw_pkg::AngTwoPi;
		end else if (z_a1 < -ssw_pkg::AngPi) begin
			z2_n = z_a1 + ssw_pkg::AngTwoPi;
		end else begin
			z2_n = z_a1;
		end
		if (z_a2 > ssw_pkg::AngPi) begin
			z3_n = z_a2 - ssw_pkg::AngTwoPi;
		end else if (z_a2 < -ssw_pkg::AngPi) begin
			z3_n = z_a2 + ssw_pkg::AngTwoPi;
		end else begin
			z3_n = z_a2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_c1 <= '0;
			sd_c2 <= '0;
			sd_a1 <= '0;
			sd_a2 <= '0;
			sd_a3 <= '0;
		end else if (en) begin
			sd_c1 <= sd_s[DivSteps];
			sd_c2 <= sd_c1;
			sd_a1 <= sd_c2;
			sd_a2 <= sd_a1;
			sd_a3 <= sd_a2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_c1 <= p1[59:30];
			q_c1  <= q_s[DivSteps];
			rm_c1 <= rm_s[DivSteps];
			z_c1  <= z_s[DivSteps];
			s3_c2 <= p2[59:30];
			rm_c2 <= rm_c1;
			z_c2  <= z_c1;
			z_a1  <= z1_n;
			rm_a1 <= rm_c2;
			z_a2  <= z2_n;
			rm_a2 <= rm_a1;
			z_a3  <= z3_n;
			rm_a3 <= rm_a2;
		end
	end

	// fold into the right half plane
	ssw_pkg::vec_t  rx_q;
	ssw_pkg::ang_t  rz_q;
	ssw_pkg::side_t sd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_q <= '0;
		end else if (en) begin
			sd_q <= sd_a3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_a3 > ssw_pkg::AngHalfPi) begin
				rz_q <= z_a3 - ssw_pkg::AngPi;
				rx_q <= -rm_a3;
			end else if (z_a3 < -ssw_pkg::AngHalfPi) begin
				rz_q <= z_a3 + ssw_pkg::AngPi;
				rx_q <= -rm_a3;
			end else begin
				rz_q <= z_a3;
				rx_q <= rm_a3;
			end
		end
	end

	assign side_out = sd_q;
	assign rx       = rx_q;
	assign rz       = rz_q;

endmodule

`default_nettype wire

// File: rtl/core/ssw_rotate.sv
// ----------------------------------------------------------------------------
// ssw_rotate
// Rotation CORDIC pipeline with rounding, saturation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssw_rotate (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire ssw_pkg::side_t side_in,
	input  wire ssw_pkg::vec_t  rx,
	input  wire ssw_pkg::ang_t  rz,
	output logic                valid,
	output ssw_pkg::coord_t     x_out,
	output ssw_pkg::coord_t     y_out,
	output logic                clipped
);

	localparam int RndWidth = ssw_pkg::VecWidth + 1 - ssw_pkg::GuardBits;

	ssw_pkg::vec_t  x_s  [ssw_pkg::Stages+1];
	ssw_pkg::vec_t  y_s  [ssw_pkg::Stages+1];
	ssw_pkg::ang_t  z_s  [ssw_pkg::Stages+1];
	ssw_pkg::side_t sd_s [ssw_pkg::Stages+1];

	assign x_s[0]  = rx;
	assign y_s[0]  = '0;
	assign z_s[0]  = rz;
	assign sd_s[0] = side_in;

	for (genvar i = 0; i < ssw_pkg::Stages; i++) begin : g_stage
		ssw_pkg::vec_t xs, ys;
		ssw_pkg::ang_t at;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		assign at = ssw_pkg::atan_q30(5'(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sd_s[i+1] <= '0;
			end else if (en) begin
				sd_s[i+1] <= sd_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	// round to nearest and saturate
	logic signed [ssw_pkg::VecWidth:0] xr, yr;
	logic signed [RndWidth-1:0]        xq, yq;
	ssw_pkg::coord_t                   xo, yo;
	logic                              xc, yc;
	localparam logic signed [RndWidth-1:0] Hi = RndWidth'(2 ** (ssw_pkg::CoordWidth - 1) - 1);
	localparam logic signed [RndWidth-1:0] Lo = -Hi - RndWidth'(1);

	always_comb begin
		xr = (ssw_pkg::VecWidth+1)'(x_s[ssw_pkg::Stages])
		     + (ssw_pkg::VecWidth+1)'(2 ** (ssw_pkg::GuardBits - 1));
		yr = (ssw_pkg::VecWidth+1)'(y_s[ssw_pkg::Stages])
		     + (ssw_pkg::VecWidth+1)'(2 ** (ssw_pkg::GuardBits - 1));
		xq = RndWidth'(xr >>> ssw_pkg::GuardBits);
		yq = RndWidth'(yr >>> ssw_pkg::GuardBits);
		xc = (xq > Hi) || (xq < Lo);
		yc = (yq > Hi) || (yq < Lo);
		xo = (xq > Hi) ? ssw_pkg::CoordWidth'(Hi) :
		     (xq < Lo) ? ssw_pkg::CoordWidth'(Lo) : ssw_pkg::CoordWidth'(xq);
		yo = (yq > Hi) ? ssw_pkg::CoordWidth'(Hi) :
		     (yq < Lo) ? ssw_pkg::CoordWidth'(Lo) : ssw_pkg::CoordWidth'(yq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (en) begin
			valid <= sd_s[ssw_pkg::Stages].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sd_s[ssw_pkg::Stages].bypass) begin
				x_out   <= sd_s[ssw_pkg::Stages].xi;
				y_out   <= sd_s[ssw_pkg::Stages].yi;
				clipped <= 1'b0;
			end else begin
				x_out   <= xo;
				y_out   <= yo;
				clipped <= xc || yc;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/spiral_swirl_warp_top.sv
// ----------------------------------------------------------------------------
// spiral_swirl_warp_top
// Swirl warp of one Q4.12 point per clock with cubic fall-off.
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready with x_in, y_in; one transfer per point
// output channel: out_valid/out_ready with x_out, y_out, clipped
// config channel: cfg_valid/cfg_ready with swirl_radius, always ready;
// write only while the pipeline is empty
// latency: 71 cycles from the input transfer to the output transfer (16
// vectoring stages, 2 gain stages, 30 divider stages, 6 fall-off stages,
// 16 rotation stages and the output register)
// throughput: one point per cycle, set by the fully pipelined datapath
// when the receiver stalls the whole pipeline holds and in_ready falls;
// the held result stays on the output unchanged
// reset clears every valid bit and sets swirl_radius to 1.0
// ----------------------------------------------------------------------------
`default_nettype none

module spiral_swirl_warp_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire ssw_pkg::coord_t       x_in,
	input  wire ssw_pkg::coord_t       y_in,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output ssw_pkg::coord_t            x_out,
	output ssw_pkg::coord_t            y_out,
	output logic                       clipped,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire ssw_pkg::rad_t         swirl_radius
);

	ssw_pkg::rad_t  radius_q;
	ssw_pkg::side_t side_in, side_v, side_f;
	ssw_pkg::vec_t  mag, rx;
	ssw_pkg::ang_t  ang, rz;
	logic           en;

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= ssw_pkg::RadReset;
		end else if (cfg_valid && cfg_ready) begin
			radius_q <= swirl_radius;
		end
	end

	always_comb begin
		side_in.valid  = in_valid;
		side_in.bypass = 1'b0;
		side_in.xi     = x_in;
		side_in.yi     = y_in;
	end

	ssw_vector u_vector (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.side_in  (side_in),
		.side_out (side_v),
		.mag      (mag),
		.ang      (ang)
	);

	ssw_falloff u_falloff (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.radius   (radius_q),
		.side_in  (side_v),
		.mag      (mag),
		.ang      (ang),
		.side_out (side_f),
		.rx       (rx),
		.rz       (rz)
	);

	ssw_rotate u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.side_in (side_f),
		.rx      (rx),
		.rz      (rz),
		.valid   (out_valid),
		.x_out   (x_out),
		.y_out   (y_out),
		.clipped (clipped)
	);

endmodule

`default_nettype wire

// File: sim/spiral_swirl_warp_top_tb.sv
// ----------------------------------------------------------------------------
// spiral_swirl_warp_top_tb
// Swirl warp testbench: directed corner points and random point streams
// under several radius settings, with random sender gaps and receiver stalls.
// Each result is compared against a cycle-free fixed-point model of the warp.
// ----------------------------------------------------------------------------
`default_nettype none

module spiral_swirl_warp_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 71;
	localparam longint LIMIT = 400000;
	localparam longint ANG_PI = 64'sd3373259426;
	localparam longint ANG_TWO_PI = 64'sd6746518852;

	typedef struct {
		ssw_pkg::coord_t x;
		ssw_pkg::coord_t y;
		logic            clip;
	} warp_res_t;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	ssw_pkg::coord_t x_in;
	ssw_pkg::coord_t y_in;
	logic            out_valid;
	logic            out_ready;
	ssw_pkg::coord_t x_out;
	ssw_pkg::coord_t y_out;
	logic            clipped;
	logic            cfg_valid;
	logic            cfg_ready;
	ssw_pkg::rad_t   swirl_radius;

	spiral_swirl_warp_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .x_in(x_in), .y_in(y_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.x_out(x_out), .y_out(y_out), .clipped(clipped),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .swirl_radius(swirl_radius)
	);

	warp_res_t   pending_pts[$];
	logic [14:0] radius_q;
	int          errors;
	int          sent;
	int          received;
	int          clip_seen;
	int          bypass_seen;
	longint      cycles;
	int          stall_mode;
	logic        gap_enable;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint atan_val(int i);
		longint tab[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
			262144, 131072, 65536, 32768};
		return tab[i];
	endfunction

	function automatic longint gain_mul(longint a, longint k);
		return (((a >>> 16) * k) >>> 14) + (((a & 64'hFFFF) * k) >>> 30);
	endfunction

	function automatic longint round_sat(longint v, ref logic clip);
		longint r;
		r = (v + 128) >>> 8;
		if (r > 32767) begin
			clip = 1'b1;
			return 32767;
		end
		if (r < -32768) begin
			clip = 1'b1;
			return -32768;
		end
		return r;
	endfunction

	function automatic warp_res_t swirl_point(ssw_pkg::coord_t xi, ssw_pkg::coord_t yi);
		warp_res_t res;
		longint x, y, z, nx, ny, d, rad, sq, s3, mag;
		logic clip;
		x = longint'(xi) * 256;
		y = longint'(yi) * 256;
		z = 0;
		clip = 1'b0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = ANG_PI;
		end
		for (int i = 0; i < 16; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += atan_val(i);
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_val(i);
			end
			x = nx;
			y = ny;
		end
		d = gain_mul(x, 652032874);
		rad = longint'(radius_q) << 8;
		if (d >= rad) begin
			res.x = xi;
			res.y = yi;
			res.clip = 1'b0;
			return res;
		end
		sq = ((rad - d) << 30) / rad;
		if (sq > 64'd1073741824) sq = 1073741824;
		s3 = (((sq * sq) >>> 30) * sq) >>> 30;
		z += 5 * s3;
		while (z > ANG_PI) z -= ANG_TWO_PI;
		while (z < -ANG_PI) z += ANG_TWO_PI;
		mag = gain_mul(x, 395948876);
		x = mag;
		y = 0;
		if (z > 1686629713) begin
			z -= ANG_PI; x = -x;
		end else if (z < -1686629713) begin
			z += ANG_PI; x = -x;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_val(i);
			end else begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += atan_val(i);
			end
			x = nx;
			y = ny;
		end
		res.x = ssw_pkg::coord_t'(round_sat(x, clip));
		res.y = ssw_pkg::coord_t'(round_sat(y, clip));
		res.clip = clip;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, received);
		errors++;
	endtask

	// cycle limit and receiver stall pattern
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 1) != 0);
			default: out_ready <= ((cycles % 23) > 15) ? 1'b0 : 1'b1;
		endcase
	end

	// result checker
	always @(posedge clk) begin
		warp_res_t want;
		if (arst_n && out_valid && out_ready) begin
			received <= received + 1;
			if (pending_pts.size() == 0) begin
				report_mismatch("unexpected transfer x_out", x_out, 0);
			end else begin
				want = pending_pts.pop_front();
				if (x_out !== want.x) report_mismatch("x_out", x_out, want.x);
				if (y_out !== want.y) report_mismatch("y_out", y_out, want.y);
				if (clipped !== want.clip) report_mismatch("clipped", clipped, want.clip);
				if (want.clip) clip_seen++;
			end
		end
	end

	task automatic send_point(ssw_pkg::coord_t px, ssw_pkg::coord_t py);
		warp_res_t want;
		if (gap_enable && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_in <= px;
		y_in <= py;
		do @(posedge clk); while (!in_ready);
		want = swirl_point(px, py);
		if (want.x == px && want.y == py && !want.clip) bypass_seen++;
		pending_pts.push_back(want);
		sent++;
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending_pts.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_radius(ssw_pkg::rad_t r);
		drain_pipe();
		cfg_valid <= 1'b1;
		swirl_radius <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		radius_q = r;
	endtask

	task automatic test_corners();
		ssw_pkg::coord_t pts[] = '{16'sh7FFF, -16'sh8000, 16'sh0000, 16'sh0001,
			-16'sh0001, 16'sh0800, -16'sh0800};
		send_point(0, 0);
		send_point(16'sh7FFF, 16'sh7FFF);
		send_point(-16'sh8000, -16'sh8000);
		send_point(-16'sh8000, 16'sh7FFF);
		send_point(16'sh7FFF, -16'sh8000);
		foreach (pts[i]) send_point(pts[i], pts[(i + 3) % pts.size()]);
		send_point(-16'sh0400, 16'sh0010);
		send_point(-16'sh0400, -16'sh0010);
		send_point(16'sh0000, -16'sh0200);
		send_point(16'sh1000, 16'sh0000);
		send_point(16'sh0B50, 16'sh0B50);
		send_point(16'sh0001, 16'sh0000);
	endtask

	task automatic test_random(int count, int span);
		ssw_pkg::coord_t px, py;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 4) == 0) begin
				px = ssw_pkg::coord_t'($urandom);
				py = ssw_pkg::coord_t'($urandom);
			end else begin
				px = ssw_pkg::coord_t'($urandom_range(0, 2 * span) - span);
				py = ssw_pkg::coord_t'($urandom_range(0, 2 * span) - span);
			end
			send_point(px, py);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		x_in = '0;
		y_in = '0;
		out_ready = 1'b1;
		cfg_valid = 1'b0;
		swirl_radius = ssw_pkg::RadReset;
		radius_q = ssw_pkg::RadReset;
		errors = 0;
		sent = 0;
		received = 0;
		clip_seen = 0;
		bypass_seen = 0;
		cycles = 0;
		stall_mode = 0;
		gap_enable = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		gap_enable = 1'b1;
		stall_mode = 1;
		test_random(200, 4096);
		write_radius(15'h7FFF);
		test_corners();
		stall_mode = 2;
		test_random(250, 32767);
		write_radius(15'd1);
		test_random(100, 8);
		write_radius(15'd0);
		test_random(50, 4096);
		write_radius(15'd20000);
		stall_mode = 3;
		test_random(200, 24000);
		write_radius(15'd2048);
		stall_mode = 0;
		gap_enable = 1'b0;
		test_random(100, 2048);
		gap_enable = 1'b1;
		stall_mode = 1;
		test_random(100, 3000);
		drain_pipe();

		$display("covered %0d points over six radius settings; %0d results checked",
			sent, received);
		$display("%0d points passed through unchanged, %0d results saturated",
			bypass_seen, clip_seen);
		if (errors == 0 && pending_pts.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
